>>> rtl/fia_pkg.sv
package fia_pkg;

    localparam int LOCAL_SLOTS = 32;
    localparam int GLOBAL_IDS  = 32;

    localparam int LOC_W  = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
    localparam int GID_W  = (GLOBAL_IDS > 1) ? $clog2(GLOBAL_IDS) : 1;
    // one more code than slots: LOCAL_SLOTS itself means no slot
    localparam int SLOT_W = $clog2(LOCAL_SLOTS + 1);

    // fixed widths of the word fields
    localparam int OPC_W = 3;
    localparam int IDX_W = 5;
    localparam int ST_W  = 2;

    localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(LOCAL_SLOTS);

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC_LOCAL  = 3'd0,
        OP_FREE_LOCAL   = 3'd1,
        OP_ALLOC_GLOBAL = 3'd2,
        OP_RESERVE      = 3'd3,
        OP_UNRESERVE    = 3'd4,
        OP_TRANSLATE    = 3'd5
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_MISUSE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic              set_used;
        logic              clr_used;
        logic              map_we;
        logic [GID_W-1:0]  idx;
        logic [SLOT_W-1:0] slot;
    } t_gtab_wr;

    typedef struct packed {
        logic              used;
        logic [SLOT_W-1:0] slot;
        logic              free_found;
        logic [GID_W-1:0]  free_idx;
    } t_gtab_rd;

endpackage

>>> rtl/family_id_allocator_top.sv
// Channel  Handshake                 Word ports
// -------  ------------------------  ------------------------------------------------
// command  start high, busy low      i_opcode i_local_index i_global_index i_with_global
// result   o_done, one cycle         o_status o_slot_out o_slot_valid o_global_out
//
// Each command is accepted, which issues the link and global table reads, and the
// next cycle decides and writes back; no new command is taken during the write-back.
// o_done pulses the cycle after the write-back; the receiver cannot stall it.
// busy is high during the write-back cycle only.
// Synchronous active-low reset clears the free list to slots 0..N-1 in order, all
// globals unused and unmapped; no clearing pass is needed.
module family_id_allocator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_opcode,
    input  logic [4:0] i_local_index,
    input  logic [4:0] i_global_index,
    input  logic       i_with_global,
    output logic       o_done,
    output logic [1:0] o_status,
    output logic [4:0] o_slot_out,
    output logic       o_slot_valid,
    output logic [4:0] o_global_out
);
    import fia_pkg::*;

    logic             link_rd_en;
    logic [LOC_W-1:0] link_rd_addr;
    logic [LOC_W-1:0] link_rd_data;
    logic             link_wr_en;
    logic [LOC_W-1:0] link_wr_addr;
    logic [LOC_W-1:0] link_wr_data;
    logic             gtab_rd_en;
    logic [GID_W-1:0] gtab_rd_idx;
    t_gtab_wr         gtab_wr;
    t_gtab_rd         gtab_rd;

    fia_link_mem u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (link_rd_en),
        .i_rd_addr (link_rd_addr),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data),
        .o_rd_data (link_rd_data)
    );

    fia_gid_tab u_gtab (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (gtab_rd_en),
        .i_rd_idx (gtab_rd_idx),
        .i_wr     (gtab_wr),
        .o_rd     (gtab_rd)
    );

    fia_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_local_index  (i_local_index),
        .i_global_index (i_global_index),
        .i_with_global  (i_with_global),
        .o_link_rd_en   (link_rd_en),
        .o_link_rd_addr (link_rd_addr),
        .i_link_rd_data (link_rd_data),
        .o_link_wr_en   (link_wr_en),
        .o_link_wr_addr (link_wr_addr),
        .o_link_wr_data (link_wr_data),
        .o_gtab_rd_en   (gtab_rd_en),
        .o_gtab_rd_idx  (gtab_rd_idx),
        .o_gtab_wr      (gtab_wr),
        .i_gtab_rd      (gtab_rd),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_slot_out     (o_slot_out),
        .o_slot_valid   (o_slot_valid),
        .o_global_out   (o_global_out)
    );

endmodule

>>> rtl/fia_link_mem.sv
module fia_link_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [fia_pkg::LOC_W-1:0] i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [fia_pkg::LOC_W-1:0] i_wr_addr,
    input  logic [fia_pkg::LOC_W-1:0] i_wr_data,
    output logic [fia_pkg::LOC_W-1:0] o_rd_data
);
    import fia_pkg::*;

    logic [LOC_W-1:0]       r_mem [LOCAL_SLOTS];
    logic [LOCAL_SLOTS-1:0] r_valid;
    logic [LOC_W-1:0]       r_rd_data;
    logic [LOC_W-1:0]       r_rd_addr;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // unwritten entry holds its reset link: the next slot up
    assign o_rd_data = r_rd_valid ? r_rd_data : LOC_W'(r_rd_addr + 1'b1);

endmodule

>>> rtl/fia_gid_tab.sv
module fia_gid_tab (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [fia_pkg::GID_W-1:0] i_rd_idx,
    input  fia_pkg::t_gtab_wr         i_wr,
    output fia_pkg::t_gtab_rd         o_rd
);
    import fia_pkg::*;

    logic [SLOT_W-1:0]     r_slot_mem [GLOBAL_IDS];
    logic [GLOBAL_IDS-1:0] r_slot_valid;
    logic [GLOBAL_IDS-1:0] r_used;
    logic [SLOT_W-1:0]     r_rd_slot;
    logic                  r_rd_slot_valid;
    logic                  r_rd_used;
    logic                  r_free_found;
    logic [GID_W-1:0]      r_free_idx;
    logic [GID_W:0]        free_srch;

    function automatic logic [GID_W:0] first_free(input logic [GLOBAL_IDS-1:0] used);
        logic [GID_W:0] res;
        res = '0;
        for (int k = GLOBAL_IDS - 1; k >= 0; k--) begin
            if (!used[k]) begin
                res = {1'b1, GID_W'(k)};
            end
        end
        return res;
    endfunction

    assign free_srch = first_free(r_used);

    always_ff @(posedge i_clk) begin
        if (i_wr.map_we) begin
            r_slot_mem[i_wr.idx] <= i_wr.slot;
        end
        if (i_rd_en) begin
            r_rd_slot    <= r_slot_mem[i_rd_idx];
            r_free_idx   <= free_srch[GID_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid    <= '0;
            r_used          <= '0;
            r_rd_slot_valid <= 1'b0;
            r_rd_used       <= 1'b0;
            r_free_found    <= 1'b0;
        end else begin
            if (i_wr.map_we) begin
                r_slot_valid[i_wr.idx] <= 1'b1;
            end
            if (i_wr.set_used) begin
                r_used[i_wr.idx] <= 1'b1;
            end else if (i_wr.clr_used) begin
                r_used[i_wr.idx] <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_slot_valid <= r_slot_valid[i_rd_idx];
                r_rd_used       <= r_used[i_rd_idx];
                r_free_found    <= free_srch[GID_W];
            end
        end
    end

    assign o_rd.used       = r_rd_used;
    assign o_rd.slot       = r_rd_slot_valid ? r_rd_slot : SLOT_NONE;
    assign o_rd.free_found = r_free_found;
    assign o_rd.free_idx   = r_free_idx;

endmodule

>>> rtl/fia_ctrl.sv
module fia_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [fia_pkg::OPC_W-1:0] i_opcode,
    input  logic [fia_pkg::IDX_W-1:0] i_local_index,
    input  logic [fia_pkg::IDX_W-1:0] i_global_index,
    input  logic                      i_with_global,
    output logic                      o_link_rd_en,
    output logic [fia_pkg::LOC_W-1:0] o_link_rd_addr,
    input  logic [fia_pkg::LOC_W-1:0] i_link_rd_data,
    output logic                      o_link_wr_en,
    output logic [fia_pkg::LOC_W-1:0] o_link_wr_addr,
    output logic [fia_pkg::LOC_W-1:0] o_link_wr_data,
    output logic                      o_gtab_rd_en,
    output logic [fia_pkg::GID_W-1:0] o_gtab_rd_idx,
    output fia_pkg::t_gtab_wr         o_gtab_wr,
    input  fia_pkg::t_gtab_rd         i_gtab_rd,
    output logic                      o_done,
    output logic [fia_pkg::ST_W-1:0]  o_status,
    output logic [fia_pkg::IDX_W-1:0] o_slot_out,
    output logic                      o_slot_valid,
    output logic [fia_pkg::IDX_W-1:0] o_global_out
);
    import fia_pkg::*;

    t_state r_state, n_state;

    logic [OPC_W-1:0]       r_op;
    logic [IDX_W-1:0]       r_li;
    logic [IDX_W-1:0]       r_gi;
    logic                   r_wg;
    logic [SLOT_W-1:0]      r_free_head, n_free_head;
    logic [LOC_W-1:0]       r_free_tail, n_free_tail;
    logic [LOCAL_SLOTS-1:0] r_slot_busy, n_slot_busy;

    logic                   r_done;
    t_status                r_status, n_status;
    logic [IDX_W-1:0]       r_slot_out, n_slot_out;
    logic                   r_slot_valid, n_slot_valid;
    logic [IDX_W-1:0]       r_global_out, n_global_out;

    logic                   accept;
    logic                   exec;
    logic                   head_empty;
    logic                   li_ok;
    logic                   gi_ok;
    logic [LOC_W-1:0]       li_idx;
    logic [LOC_W-1:0]       head_idx;

    assign accept     = start && !busy;
    assign exec       = (r_state == S_EXEC);
    assign head_empty = (r_free_head == SLOT_NONE);
    assign li_ok      = 32'(r_li) < 32'(LOCAL_SLOTS);
    assign gi_ok      = 32'(r_gi) < 32'(GLOBAL_IDS);
    assign li_idx     = LOC_W'(r_li);
    assign head_idx   = LOC_W'(r_free_head);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy           = (r_state == S_EXEC);
        o_link_rd_en   = accept;
        o_link_rd_addr = head_idx;
        o_gtab_rd_en   = accept;
        o_gtab_rd_idx  = GID_W'(i_global_index);
    end

    // execute step: table reads are back, decide and write back
    always_comb begin
        n_free_head    = r_free_head;
        n_free_tail    = r_free_tail;
        n_slot_busy    = r_slot_busy;
        n_status       = ST_OK;
        n_slot_out     = '0;
        n_slot_valid   = 1'b0;
        n_global_out   = '0;
        o_link_wr_en   = 1'b0;
        o_link_wr_addr = r_free_tail;
        o_link_wr_data = li_idx;
        o_gtab_wr      = '{set_used: 1'b0, clr_used: 1'b0, map_we: 1'b0,
                           idx: GID_W'(r_gi), slot: SLOT_NONE};
        unique case (r_op)
            OP_ALLOC_LOCAL: begin
                if (head_empty) begin
                    n_status = ST_EMPTY;
                end else if (r_wg && !(gi_ok && i_gtab_rd.used)) begin
                    n_status = ST_MISUSE;
                end else begin
                    o_gtab_wr.map_we = r_wg;
                    o_gtab_wr.slot   = r_free_head;
                    // last empty slot: its link is never followed
                    n_free_head = (head_idx == r_free_tail) ? SLOT_NONE
                                                           : SLOT_W'(i_link_rd_data);
                    n_slot_busy[head_idx] = 1'b1;
                    n_slot_out   = IDX_W'(head_idx);
                    n_slot_valid = 1'b1;
                end
            end
            OP_FREE_LOCAL: begin
                if (!li_ok || !r_slot_busy[li_idx]) begin
                    n_status = ST_MISUSE;
                end else begin
                    if (head_empty) begin
                        n_free_head = SLOT_W'(li_idx);
                    end else begin
                        o_link_wr_en = 1'b1;
                    end
                    n_free_tail          = li_idx;
                    n_slot_busy[li_idx]  = 1'b0;
                end
            end
            OP_ALLOC_GLOBAL: begin
                if (!i_gtab_rd.free_found) begin
                    n_status = ST_EMPTY;
                end else begin
                    o_gtab_wr.set_used = 1'b1;
                    o_gtab_wr.map_we   = 1'b1;
                    o_gtab_wr.idx      = i_gtab_rd.free_idx;
                    o_gtab_wr.slot     = li_ok ? SLOT_W'(li_idx) : SLOT_NONE;
                    n_global_out       = IDX_W'(i_gtab_rd.free_idx);
                end
            end
            OP_RESERVE: begin
                if (!gi_ok || i_gtab_rd.used) begin
                    n_status = ST_MISUSE;
                end else begin
                    o_gtab_wr.set_used = 1'b1;
                end
            end
            OP_UNRESERVE: begin
                if (!gi_ok || !i_gtab_rd.used) begin
                    n_status = ST_MISUSE;
                end else begin
                    o_gtab_wr.clr_used = 1'b1;
                    o_gtab_wr.map_we   = 1'b1;
                end
            end
            OP_TRANSLATE: begin
                if (!gi_ok || !i_gtab_rd.used) begin
                    n_status = ST_MISUSE;
                end else if (i_gtab_rd.slot != SLOT_NONE) begin
                    n_slot_out   = IDX_W'(i_gtab_rd.slot);
                    n_slot_valid = 1'b1;
                end
            end
            default: begin
                n_status = ST_MISUSE;
            end
        endcase
        if (!exec) begin
            o_link_wr_en       = 1'b0;
            o_gtab_wr.set_used = 1'b0;
            o_gtab_wr.clr_used = 1'b0;
            o_gtab_wr.map_we   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_opcode;
            r_li <= i_local_index;
            r_gi <= i_global_index;
            r_wg <= i_with_global;
        end
        if (exec) begin
            r_status     <= n_status;
            r_slot_out   <= n_slot_out;
            r_slot_valid <= n_slot_valid;
            r_global_out <= n_global_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_free_head <= '0;
            r_free_tail <= LOC_W'(LOCAL_SLOTS - 1);
            r_slot_busy <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= exec;
            if (exec) begin
                r_free_head <= n_free_head;
                r_free_tail <= n_free_tail;
                r_slot_busy <= n_slot_busy;
            end
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_slot_out   = r_slot_out;
    assign o_slot_valid = r_slot_valid;
    assign o_global_out = r_global_out;

endmodule
